// File: rtl/eptc_pkg.sv
`default_nettype none
package eptc_pkg;

	localparam int unsigned EPOCH_BITS_DEF = 32;
	localparam int unsigned NUM_STAGES     = 12;

	typedef logic [NUM_STAGES-1:0] stage_en_t;

	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned MINS_PER_HOUR = 60;
	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned DAY_SHIFT     = 7;
	localparam int unsigned DAYS_TO_EPOCH = 719468;
	localparam int unsigned DAYS_PER_ERA  = 146097;
	localparam int unsigned DAYS_PER_YEAR = 365;
	localparam int unsigned YEARS_PER_ERA = 400;
	localparam int unsigned YEAR_BASE     = 1900;
	localparam int unsigned MAR_TO_JAN    = 10;
	localparam int unsigned JAN_TO_MAR    = 2;

	// exact floor division by constants: q = (x * RCP) >> SH over the x range of each use
	localparam int unsigned RCP_1460_SH = 29;
	localparam logic [18:0] RCP_1460 =
		19'(((64'd1 << RCP_1460_SH) + 64'd1459) / 64'd1460);
	localparam int unsigned RCP_36524_SH = 34;
	localparam logic [18:0] RCP_36524 =
		19'(((64'd1 << RCP_36524_SH) + 64'd36523) / 64'd36524);
	localparam int unsigned RCP_365_SH = 27;
	localparam logic [18:0] RCP_365 =
		19'(((64'd1 << RCP_365_SH) + 64'd364) / 64'd365);
	localparam int unsigned RCP_100_SH = 16;
	localparam logic [9:0] RCP_100 =
		10'(((64'd1 << RCP_100_SH) + 64'd99) / 64'd100);
	localparam int unsigned RCP_153_SH = 19;
	localparam logic [11:0] RCP_153 =
		12'(((64'd1 << RCP_153_SH) + 64'd152) / 64'd153);
	localparam int unsigned RCP_5_SH = 14;
	localparam logic [11:0] RCP_5 =
		12'(((64'd1 << RCP_5_SH) + 64'd4) / 64'd5);
	localparam int unsigned RCP_60S_SH = 23;
	localparam logic [17:0] RCP_60S =
		18'(((64'd1 << RCP_60S_SH) + 64'd59) / 64'd60);
	localparam int unsigned RCP_60M_SH = 17;
	localparam logic [11:0] RCP_60M =
		12'(((64'd1 << RCP_60M_SH) + 64'd59) / 64'd60);

endpackage
`default_nettype wire

// File: rtl/eptc_ctrl.sv
`default_nettype none
module eptc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output eptc_pkg::stage_en_t en
);

	localparam int unsigned NS = eptc_pkg::NUM_STAGES;

	logic [NS-1:0] stage_valid_q;

	// a stage loads when empty or when its content moves on
	always_comb begin
		en[NS-1] = !stage_valid_q[NS-1] || out_ready;
		for (int i = NS - 2; i >= 0; i--) begin
			en[i] = !stage_valid_q[i] || en[i+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = stage_valid_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (en[0]) begin
				stage_valid_q[0] <= in_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					stage_valid_q[i] <= stage_valid_q[i-1];
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/eptc_day_split.sv
`default_nettype none
module eptc_day_split #(
	parameter int unsigned EB = eptc_pkg::EPOCH_BITS_DEF
) (
	input  wire                 clk,
	input  eptc_pkg::stage_en_t en,
	input  wire  [EB-1:0]       epoch_seconds,
	output logic [EB-17:0]      days,
	output logic [16:0]         sec_of_day
);

	localparam int unsigned UB = EB - eptc_pkg::DAY_SHIFT;
	localparam int unsigned MB = EB - 16;
	localparam int unsigned PW = UB + MB;
	localparam logic [MB-1:0] RCP_DAY =
		MB'((64'd1 << UB) / (eptc_pkg::SECS_PER_DAY >> eptc_pkg::DAY_SHIFT));

	logic [EB-1:0] t_s1, t_s2;
	logic [PW-1:0] prod_s1;
	logic [MB-1:0] days_est_s2, days_s3;
	logic [EB-1:0] day_base_s2;
	logic [16:0]   sod_s3;
	logic [17:0]   rem;

	assign rem = 18'(t_s2 - day_base_s2);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1    <= epoch_seconds;
			prod_s1 <= PW'(epoch_seconds[EB-1:eptc_pkg::DAY_SHIFT]) * PW'(RCP_DAY);
		end
		if (en[1]) begin
			t_s2        <= t_s1;
			days_est_s2 <= prod_s1[PW-1:UB];
			day_base_s2 <= EB'(EB'(prod_s1[PW-1:UB]) * EB'(eptc_pkg::SECS_PER_DAY));
		end
		if (en[2]) begin
			if (rem >= 18'(eptc_pkg::SECS_PER_DAY)) begin
				days_s3 <= days_est_s2 + MB'(1);
				sod_s3  <= 17'(rem - 18'(eptc_pkg::SECS_PER_DAY));
			end else begin
				days_s3 <= days_est_s2;
				sod_s3  <= 17'(rem);
			end
		end
	end

	assign days       = days_s3;
	assign sec_of_day = sod_s3;

endmodule
`default_nettype wire

// File: rtl/eptc_tod.sv
`default_nettype none
module eptc_tod (
	input  wire                 clk,
	input  eptc_pkg::stage_en_t en,
	input  wire  [16:0]         sec_of_day,
	output logic [5:0]          second_of_minute,
	output logic [5:0]          minute_of_hour,
	output logic [4:0]          hour_of_day
);

	localparam int unsigned DLY = 7;

	logic [16:0] sod_dly_q [DLY];
	logic [10:0] min_of_day;
	logic [10:0] min_of_day_s11;
	logic [5:0]  sec_s11, sec_s12, min_s12;
	logic [4:0]  hour, hour_s12;

	assign min_of_day = 11'((35'(sod_dly_q[DLY-1]) * 35'(eptc_pkg::RCP_60S))
		>> eptc_pkg::RCP_60S_SH);
	assign hour = 5'((23'(min_of_day_s11) * 23'(eptc_pkg::RCP_60M))
		>> eptc_pkg::RCP_60M_SH);

	// time of day waits alongside the date path
	always_ff @(posedge clk) begin
		if (en[3]) begin
			sod_dly_q[0] <= sec_of_day;
		end
		for (int i = 1; i < DLY; i++) begin
			if (en[3+i]) begin
				sod_dly_q[i] <= sod_dly_q[i-1];
			end
		end
		if (en[10]) begin
			min_of_day_s11 <= min_of_day;
			sec_s11 <= 6'(sod_dly_q[DLY-1]
				- 17'(min_of_day) * 17'(eptc_pkg::SECS_PER_MIN));
		end
		if (en[11]) begin
			sec_s12  <= sec_s11;
			hour_s12 <= hour;
			min_s12  <= 6'(min_of_day_s11 - 11'(hour) * 11'(eptc_pkg::MINS_PER_HOUR));
		end
	end

	assign second_of_minute = sec_s12;
	assign minute_of_hour   = min_s12;
	assign hour_of_day      = hour_s12;

endmodule
`default_nettype wire

// File: rtl/eptc_date.sv
`default_nettype none
module eptc_date #(
	parameter int unsigned EB = eptc_pkg::EPOCH_BITS_DEF
) (
	input  wire                 clk,
	input  eptc_pkg::stage_en_t en,
	input  wire  [EB-17:0]      days,
	output logic [4:0]          day_of_month,
	output logic [3:0]          month_index,
	output logic [7:0]          years_since_1900
);

	localparam int unsigned DW = EB - 16;
	localparam int unsigned ZW = (DW >= 20) ? DW + 1 : 21;
	localparam int unsigned EW = ZW - 17;
	localparam int unsigned PW = ZW + EW;
	localparam logic [EW-1:0] RCP_ERA =
		EW'((64'd1 << ZW) / 64'(eptc_pkg::DAYS_PER_ERA));

	logic [ZW-1:0] z, z_s4, z_s5, era_base_s5;
	logic [PW-1:0] era_prod_s4;
	logic [EW-1:0] era_s5, era_s6, era_s7, era_s8, era_s9, era_s10, era_s11;
	logic [18:0]   doe_raw;
	logic [17:0]   doe_s6, doe_s7, doe_s8, doe_s9;
	logic [6:0]    q1460_s7;
	logic [2:0]    q36524_s7;
	logic          last_day_s7;
	logic [17:0]   num_s8;
	logic [8:0]    yoe_s9, yoe_s10, yoe_s11;
	logic [1:0]    cent;
	logic [17:0]   year_days;
	logic [8:0]    doy_s10, doy_s11;
	logic [10:0]   mp_num;
	logic [3:0]    mp_s11;
	logic [10:0]   day_num;
	logic [8:0]    day_off;
	logic [3:0]    mon;
	logic [4:0]    day_s12;
	logic [3:0]    mon_s12;
	logic [7:0]    year_s12;

	assign z       = ZW'(days) + ZW'(eptc_pkg::DAYS_TO_EPOCH);
	assign doe_raw = 19'(z_s5 - era_base_s5);
	assign cent    = 2'((19'(yoe_s9) * 19'(eptc_pkg::RCP_100)) >> eptc_pkg::RCP_100_SH);
	assign year_days = 18'(yoe_s9) * 18'(eptc_pkg::DAYS_PER_YEAR)
		+ 18'(yoe_s9 >> 2) - 18'(cent);
	assign mp_num  = 11'(doy_s10) * 11'(5) + 11'(2);
	assign day_num = 11'(mp_s11) * 11'(153) + 11'(2);
	assign day_off = 9'((24'(day_num) * 24'(eptc_pkg::RCP_5)) >> eptc_pkg::RCP_5_SH);
	assign mon     = (mp_s11 < 4'(eptc_pkg::MAR_TO_JAN)) ?
		mp_s11 + 4'(eptc_pkg::JAN_TO_MAR) : mp_s11 - 4'(eptc_pkg::MAR_TO_JAN);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			z_s4        <= z;
			era_prod_s4 <= PW'(z) * PW'(RCP_ERA);
		end
		if (en[4]) begin
			z_s5        <= z_s4;
			era_s5      <= era_prod_s4[PW-1:ZW];
			era_base_s5 <= ZW'(ZW'(era_prod_s4[PW-1:ZW]) * ZW'(eptc_pkg::DAYS_PER_ERA));
		end
		if (en[5]) begin
			if (doe_raw >= 19'(eptc_pkg::DAYS_PER_ERA)) begin
				era_s6 <= era_s5 + EW'(1);
				doe_s6 <= 18'(doe_raw - 19'(eptc_pkg::DAYS_PER_ERA));
			end else begin
				era_s6 <= era_s5;
				doe_s6 <= 18'(doe_raw);
			end
		end
		if (en[6]) begin
			era_s7      <= era_s6;
			doe_s7      <= doe_s6;
			q1460_s7    <= 7'((37'(doe_s6) * 37'(eptc_pkg::RCP_1460))
				>> eptc_pkg::RCP_1460_SH);
			q36524_s7   <= 3'((37'(doe_s6) * 37'(eptc_pkg::RCP_36524))
				>> eptc_pkg::RCP_36524_SH);
			last_day_s7 <= (doe_s6 == 18'(eptc_pkg::DAYS_PER_ERA - 1));
		end
		if (en[7]) begin
			era_s8 <= era_s7;
			doe_s8 <= doe_s7;
			num_s8 <= doe_s7 - 18'(q1460_s7) + 18'(q36524_s7) - 18'(last_day_s7);
		end
		if (en[8]) begin
			era_s9 <= era_s8;
			doe_s9 <= doe_s8;
			yoe_s9 <= 9'((37'(num_s8) * 37'(eptc_pkg::RCP_365)) >> eptc_pkg::RCP_365_SH);
		end
		if (en[9]) begin
			era_s10 <= era_s9;
			yoe_s10 <= yoe_s9;
			doy_s10 <= 9'(doe_s9 - year_days);
		end
		if (en[10]) begin
			era_s11 <= era_s10;
			yoe_s11 <= yoe_s10;
			doy_s11 <= doy_s10;
			mp_s11  <= 4'((24'(mp_num) * 24'(eptc_pkg::RCP_153)) >> eptc_pkg::RCP_153_SH);
		end
		if (en[11]) begin
			day_s12  <= 5'(doy_s11 - day_off + 9'(1));
			mon_s12  <= mon;
			// January and February belong to the next March-based year
			year_s12 <= 8'(yoe_s11)
				+ 8'(era_s11 * (EW + 9)'(eptc_pkg::YEARS_PER_ERA))
				+ 8'(mon <= 4'(1))
				- 8'(eptc_pkg::YEAR_BASE);
		end
	end

	assign day_of_month     = day_s12;
	assign month_index      = mon_s12;
	assign years_since_1900 = year_s12;

endmodule
`default_nettype wire

// File: rtl/epoch_seconds_to_calendar.sv
// epoch_seconds_to_calendar
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into
// Gregorian date and time of day (full leap rule, 2100 is a common year).
// Input channel: epoch_valid / epoch_ready with epoch_seconds.
// Output channel: calendar_valid / calendar_ready with second, minute, hour,
// day of month, month index (0 = January) and year minus 1900.
// One transaction out for every transaction in, in order.
// The result passes through the twelve-stage pipeline (reciprocal multiplies,
// each followed by a register).
// Throughput: one transaction per cycle while calendar_ready does not stall
// the output.
// Each stage has its own valid bit; a stage loads when empty or when its
// content moves on, so a stalled receiver freezes only the filled stages and
// epoch_ready falls once the pipeline is full. Nothing is lost or repeated.
// Reset (arst_n low) empties the pipeline; payload registers are not cleared.
// EPOCH_BITS sets the input width; years past 2155 wrap in years_since_1900.
`default_nettype none
module epoch_seconds_to_calendar #(
	parameter int unsigned EPOCH_BITS = eptc_pkg::EPOCH_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  epoch_valid,
	output logic                 epoch_ready,
	input  wire [EPOCH_BITS-1:0] epoch_seconds,
	output logic                 calendar_valid,
	input  wire                  calendar_ready,
	output logic [5:0]           second_of_minute,
	output logic [5:0]           minute_of_hour,
	output logic [4:0]           hour_of_day,
	output logic [4:0]           day_of_month,
	output logic [3:0]           month_index,
	output logic [7:0]           years_since_1900
);

	eptc_pkg::stage_en_t    en;
	logic [EPOCH_BITS-17:0] days;
	logic [16:0]            sec_of_day;

	eptc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (epoch_valid),
		.in_ready  (epoch_ready),
		.out_valid (calendar_valid),
		.out_ready (calendar_ready),
		.en        (en)
	);

	eptc_day_split #(
		.EB (EPOCH_BITS)
	) u_day_split (
		.clk           (clk),
		.en            (en),
		.epoch_seconds (epoch_seconds),
		.days          (days),
		.sec_of_day    (sec_of_day)
	);

	eptc_tod u_tod (
		.clk              (clk),
		.en               (en),
		.sec_of_day       (sec_of_day),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day)
	);

	eptc_date #(
		.EB (EPOCH_BITS)
	) u_date (
		.clk              (clk),
		.en               (en),
		.days             (days),
		.day_of_month     (day_of_month),
		.month_index      (month_index),
		.years_since_1900 (years_since_1900)
	);

endmodule
`default_nettype wire

// File: test/epoch_seconds_to_calendar_test.sv
module epoch_seconds_to_calendar_test;

	typedef struct packed {
		logic [5:0] second_of_minute;
		logic [5:0] minute_of_hour;
		logic [4:0] hour_of_day;
		logic [4:0] day_of_month;
		logic [3:0] month_index;
		logic [7:0] years_since_1900;
	} calendar_t;

	localparam int unsigned RANDOM_ITEMS = 1400;
	localparam int unsigned MAX_WAIT     = 18;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned MAX_REPORTS  = 10;

	class calendar_scoreboard;
		calendar_t pending[$];
		int unsigned mismatches = 0;

		function calendar_t calendar_of_epoch(logic [31:0] secs);
			longint unsigned t, days, z, era, doe, yoe, doy, mp, mon, yr;
			calendar_t c;
			t = secs;
			c.second_of_minute = 6'(t % 60);
			t = t / 60;
			c.minute_of_hour = 6'(t % 60);
			t = t / 60;
			c.hour_of_day = 5'(t % 24);
			days = t / 24;
			// shift origin to 0000-03-01, split into 400-year eras
			z = days + 719468;
			era = z / 146097;
			doe = z - era * 146097;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp = (5 * doy + 2) / 153;
			c.day_of_month = 5'(doy - (153 * mp + 2) / 5 + 1);
			mon = (mp < 10) ? mp + 2 : mp - 10;
			c.month_index = 4'(mon);
			yr = yoe + era * 400 + ((mon <= 1) ? 1 : 0);
			c.years_since_1900 = 8'(yr - 1900);
			return c;
		endfunction

		function void note_epoch(logic [31:0] secs);
			pending.push_back(calendar_of_epoch(secs));
		endfunction

		function void check_calendar(calendar_t got);
			calendar_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected calendar transaction: %0d:%0d:%0d %0d/%0d/%0d",
						got.hour_of_day, got.minute_of_hour, got.second_of_minute,
						got.day_of_month, got.month_index, got.years_since_1900);
				return;
			end
			want = pending.pop_front();
			if (got != want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
						want.second_of_minute, want.minute_of_hour, want.hour_of_day,
						want.day_of_month, want.month_index, want.years_since_1900,
						got.second_of_minute, got.minute_of_hour, got.hour_of_day,
						got.day_of_month, got.month_index, got.years_since_1900);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        epoch_valid;
	logic        epoch_ready;
	logic [31:0] epoch_seconds;
	logic        calendar_valid;
	logic        calendar_ready;
	logic [5:0]  second_of_minute;
	logic [5:0]  minute_of_hour;
	logic [4:0]  hour_of_day;
	logic [4:0]  day_of_month;
	logic [3:0]  month_index;
	logic [7:0]  years_since_1900;

	calendar_scoreboard sb = new();
	int unsigned cycles = 0;
	bit send_burst = 0;
	bit recv_burst = 0;

	epoch_seconds_to_calendar uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.epoch_valid      (epoch_valid),
		.epoch_ready      (epoch_ready),
		.epoch_seconds    (epoch_seconds),
		.calendar_valid   (calendar_valid),
		.calendar_ready   (calendar_ready),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_month     (day_of_month),
		.month_index      (month_index),
		.years_since_1900 (years_since_1900)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && epoch_valid && epoch_ready)
			sb.note_epoch(epoch_seconds);
	end

	always @(posedge clk) begin
		if (arst_n && calendar_valid && calendar_ready)
			sb.check_calendar('{second_of_minute, minute_of_hour, hour_of_day,
				day_of_month, month_index, years_since_1900});
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_epoch(input logic [31:0] secs);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = ~send_burst;
		gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap != 0) begin
			epoch_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		epoch_valid <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (!epoch_ready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_epoch();
		longint unsigned day, secs;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: secs = $urandom;
			4, 5, 6: begin
				// around midnight
				day = $urandom_range(0, 49709);
				secs = day * 86400;
				if ($urandom_range(0, 1))
					secs = secs + $urandom_range(0, 3);
				else
					secs = secs + 86399 - $urandom_range(0, 3);
			end
			7, 8: begin
				// around a leap day slot, every fourth February
				day = 789 + 1461 * $urandom_range(0, 33) + $urandom_range(0, 2);
				secs = (day - 1) * 86400 + $urandom_range(0, 86399);
			end
			default: secs = 32'hFFFF_FFFF - $urandom_range(0, 200000);
		endcase
		return secs[31:0];
	endfunction

	initial begin
		calendar_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			int unsigned stall;
			if ($urandom_range(0, 39) == 0)
				recv_burst = ~recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall != 0) begin
				calendar_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			calendar_ready <= 1'b1;
			do @(posedge clk); while (!calendar_valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [31:0] directed[$];
		arst_n = 1'b0;
		epoch_valid = 1'b0;
		epoch_seconds = '0;
		directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
			32'd86400, 32'd31535999, 32'd31536000, 32'd68169600, 32'd68255999,
			32'd946684799, 32'd951782400, 32'd951868800, 32'd2147483647,
			32'd2147483648, 32'd4107456000, 32'd4107542399, 32'd4107542400,
			32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			send_epoch(directed[i]);
		repeat (RANDOM_ITEMS)
			send_epoch(pick_epoch());
		epoch_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
